@@ src/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 4;

  localparam logic [6:0]  Len7Ext16 = 7'd126;
  localparam logic [6:0]  Len7Ext64 = 7'd127;
  localparam logic [CountW-1:0] Ext16Bytes = CountW'(2);
  localparam logic [CountW-1:0] Ext64Bytes = CountW'(8);
  localparam logic [CountW-1:0] KeyBytes   = CountW'(4);

  localparam logic [OpcodeW-1:0] OpcClose = 4'h8;
  localparam logic [OpcodeW-1:0] OpcPing  = 4'h9;
  localparam logic [OpcodeW-1:0] OpcPong  = 4'hA;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASKKEY,
    PH_PAYLOAD
  } phase_e;

  // One result as produced by the parser for the accepted byte.
  typedef struct packed {
    logic               valid;
    logic [ByteW-1:0]   payload_byte;
    logic [OpcodeW-1:0] frame_opcode;
    logic               last_of_frame;
    logic               no_payload;
  } wsd_res_t;

endpackage

@@ src/wsd_parser.sv @@
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasking; one byte per accepted item.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              rx_byte_i,
  output wsd_pkg::wsd_res_t       res_o
);
  import wsd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [OpcodeW-1:0]  opcode_q, opcode_d;
  logic                mask_q, mask_d;
  logic [LenW-1:0]     length_q, length_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [1:0]          pos_q, pos_d;
  logic                closed_q, closed_d;

  logic [6:0]          len7;
  logic                len7_ext;
  logic [LenW-1:0]     len_shift;
  logic [LenW-1:0]     len_dec;
  logic                count_last;
  logic [ByteW-1:0]    key_byte;
  logic                active;

  assign active     = step_i && !closed_q;
  assign len7       = rx_byte_i[6:0];
  assign len7_ext   = (len7 == Len7Ext16) || (len7 == Len7Ext64);
  assign len_shift  = {length_q[LenW-ByteW-1:0], rx_byte_i};
  assign len_dec    = length_q - LenW'(1);
  assign count_last = (count_q == CountW'(1));
  assign key_byte   = mask_q ? key_q[(KeyW-1) - ByteW*pos_q -: ByteW] : '0;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    length_d = length_q;
    count_d  = count_q;
    key_d    = key_q;
    pos_d    = pos_q;
    closed_d = closed_q;
    if (active) begin
      unique case (phase_q)
        PH_HDR0: begin
          opcode_d = rx_byte_i[OpcodeW-1:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = rx_byte_i[7];
          if (len7_ext) begin
            length_d = '0;
            count_d  = (len7 == Len7Ext16) ? Ext16Bytes : Ext64Bytes;
            phase_d  = PH_EXTLEN;
          end else begin
            length_d = LenW'(len7);
            if (rx_byte_i[7]) begin
              key_d   = '0;
              count_d = KeyBytes;
              phase_d = PH_MASKKEY;
            end else if (len7 == 7'd0) begin
              phase_d  = PH_HDR0;
              closed_d = (opcode_q == OpcClose);
            end else begin
              pos_d   = '0;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_EXTLEN: begin
          length_d = len_shift;
          count_d  = count_q - CountW'(1);
          if (count_last) begin
            if (mask_q) begin
              key_d   = '0;
              count_d = KeyBytes;
              phase_d = PH_MASKKEY;
            end else if (len_shift == '0) begin
              phase_d  = PH_HDR0;
              closed_d = (opcode_q == OpcClose);
            end else begin
              pos_d   = '0;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_MASKKEY: begin
          key_d   = {key_q[KeyW-ByteW-1:0], rx_byte_i};
          count_d = count_q - CountW'(1);
          if (count_last) begin
            if (length_q == '0) begin
              phase_d  = PH_HDR0;
              closed_d = (opcode_q == OpcClose);
            end else begin
              pos_d   = '0;
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pos_d    = pos_q + 2'd1;
          length_d = len_dec;
          if (len_dec == '0) begin
            phase_d  = PH_HDR0;
            closed_d = (opcode_q == OpcClose);
          end
        end
        default: phase_d = PH_HDR0;
      endcase
    end
  end

  // Result for the accepted byte
  always_comb begin
    res_o = '0;
    res_o.frame_opcode = opcode_q;
    if (active) begin
      unique case (phase_q)
        PH_HDR1: begin
          if (!len7_ext && !rx_byte_i[7] && (len7 == 7'd0)) begin
            res_o.valid         = 1'b1;
            res_o.last_of_frame = 1'b1;
            res_o.no_payload    = 1'b1;
          end
        end
        PH_EXTLEN: begin
          if (count_last && !mask_q && (len_shift == '0)) begin
            res_o.valid         = 1'b1;
            res_o.last_of_frame = 1'b1;
            res_o.no_payload    = 1'b1;
          end
        end
        PH_MASKKEY: begin
          if (count_last && (length_q == '0)) begin
            res_o.valid         = 1'b1;
            res_o.last_of_frame = 1'b1;
            res_o.no_payload    = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_o.valid         = 1'b1;
          res_o.payload_byte  = rx_byte_i ^ key_byte;
          res_o.last_of_frame = (len_dec == '0);
        end
        default: res_o.valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      length_q <= '0;
      count_q  <= '0;
      key_q    <= '0;
      pos_q    <= '0;
      closed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      length_q <= length_d;
      count_q  <= count_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
      closed_q <= closed_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(closed_q) |-> closed_q)
    else $error("closed stream reopened");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXTLEN || phase_q == PH_MASKKEY) |-> (count_q != '0))
    else $error("header byte count empty in counted phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (length_q != '0))
    else $error("payload phase with zero length");

endmodule

@@ src/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: strips headers, unmasks payload bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  input     in         in_valid_i / in_stall_o rx_byte_i
//  output    out        out_valid_o/ out_stall_i payload_byte_o, frame_opcode_o,
//                                               last_of_frame_o, no_payload_o
//
//  One byte is accepted per cycle while in_stall_o is low; its result, if any,
//  appears in the output register on the next cycle. The header parser and
//  64-bit length counter update in the same cycle as the byte is taken.
//  Reset (rst_ni low, asynchronous) returns the parser to the first header
//  byte and empties the output register.
//  in_stall_o is high only while a result waits and out_stall_i is high.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       last_of_frame_o,
  output logic       no_payload_o
);
  import wsd_pkg::*;

  logic     in_accept;
  wsd_res_t res;
  logic     out_valid_q, out_valid_d;
  wsd_res_t out_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_accept),
    .rx_byte_i (rx_byte_i),
    .res_o     (res)
  );

  // Hold while stalled; otherwise load whatever the new item produced.
  always_comb begin
    out_valid_d = out_valid_q;
    if (!in_stall_o) begin
      out_valid_d = in_accept && res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_q.payload_byte;
  assign frame_opcode_o  = out_q.frame_opcode;
  assign last_of_frame_o = out_q.last_of_frame;
  assign no_payload_o    = out_q.no_payload;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_payload_o |-> last_of_frame_o && (payload_byte_o == 8'd0))
    else $error("empty-frame marker malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall without pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_valid_i |=> !out_valid_o)
    else $error("result repeated after delivery");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without accepted item");

endmodule
